// ===== rtl/bts_pkg.sv =====
// Shared types and constants of the bilinear texture sampler.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bts_pkg;

    // Default sizes handed to the top level parameters
    localparam int DEF_MAX_TEX_WIDTH  = 256;
    localparam int DEF_MAX_TEX_HEIGHT = 256;
    localparam int DEF_COLOR_BITS     = 16;

    // Size registers and their reset values
    localparam int CFG_W = 9;
    localparam logic [CFG_W-1:0] RST_TEX_WIDTH  = 9'd256;
    localparam logic [CFG_W-1:0] RST_TEX_HEIGHT = 9'd256;

    // Register port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_PRESENT = 2'd2;

    // Function codes of an input word
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Blend weights: one 16-bit fraction per axis, unity is 1 << 16
    localparam int FRAC_W = 16;
    localparam int WS_W   = FRAC_W + 1;
    localparam int WT_W   = 2 * FRAC_W + 1;
    localparam logic [WS_W-1:0] WS_ONE = 17'h1_0000;

    typedef struct packed {
        logic              func;
        logic [7:0]        write_x;
        logic [7:0]        write_y;
        logic [15:0]       color_red;
        logic [15:0]       color_green;
        logic [15:0]       color_blue;
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
        logic              tile_mode;
    } req_word_t;

    typedef struct packed {
        logic [15:0] sample_red;
        logic [15:0] sample_green;
        logic [15:0] sample_blue;
    } rsp_word_t;

    // Effective texture size and fallback switch
    typedef struct packed {
        logic [CFG_W-1:0] size_w;
        logic [CFG_W-1:0] size_h;
        logic             present;
    } size_t;

    // Control that travels with a word down the pipeline
    typedef struct packed {
        logic valid;
        logic sample;
        logic present;
        logic wr_en;
    } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/bts_cfg_regs.sv =====
// Register file of the sampler: texture size and the texture present flag.
// Depends on bts_pkg.
`default_nettype none

module bts_cfg_regs #(
    parameter int MAX_TEX_WIDTH  = bts_pkg::DEF_MAX_TEX_WIDTH,
    parameter int MAX_TEX_HEIGHT = bts_pkg::DEF_MAX_TEX_HEIGHT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bts_pkg::APB_AW-1:0]    paddr,
    input  wire logic [bts_pkg::APB_DW-1:0]    pwdata,
    output logic      [bts_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    output bts_pkg::size_t                     size
);

    logic [bts_pkg::CFG_W-1:0] width_reg;
    logic [bts_pkg::CFG_W-1:0] height_reg;
    logic                      present_reg;
    logic [1:0]                reg_sel;

    function automatic logic [bts_pkg::CFG_W-1:0] eff_size(
        input logic [bts_pkg::CFG_W-1:0] r,
        input int                        maxv
    );
        logic [bts_pkg::CFG_W-1:0] res;
        if (r == '0)
        begin
            res = bts_pkg::CFG_W'(1);
        end
        else if (32'(r) > maxv)
        begin
            res = bts_pkg::CFG_W'(maxv);
        end
        else
        begin
            res = r;
        end
        return res;
    endfunction

    assign reg_sel = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= bts_pkg::RST_TEX_WIDTH;
            height_reg  <= bts_pkg::RST_TEX_HEIGHT;
            present_reg <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                bts_pkg::REG_WIDTH:   width_reg   <= pwdata[bts_pkg::CFG_W-1:0];
                bts_pkg::REG_HEIGHT:  height_reg  <= pwdata[bts_pkg::CFG_W-1:0];
                bts_pkg::REG_PRESENT: present_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            bts_pkg::REG_WIDTH:   prdata = bts_pkg::APB_DW'(width_reg);
            bts_pkg::REG_HEIGHT:  prdata = bts_pkg::APB_DW'(height_reg);
            bts_pkg::REG_PRESENT: prdata = bts_pkg::APB_DW'(present_reg);
            default:              prdata = '0;
        endcase
    end

    assign size.size_w  = eff_size(width_reg, MAX_TEX_WIDTH);
    assign size.size_h  = eff_size(height_reg, MAX_TEX_HEIGHT);
    assign size.present = present_reg;

endmodule

`default_nettype wire

// ===== rtl/bts_addr_gen.sv =====
// Coordinate front end: scales (u,v) by the texture size, splits index and
// fraction, wraps or clamps the neighbors and forms the four blend weights.
// Depends on bts_pkg.
`default_nettype none

module bts_addr_gen #(
    parameter int MAX_TEX_WIDTH  = bts_pkg::DEF_MAX_TEX_WIDTH,
    parameter int MAX_TEX_HEIGHT = bts_pkg::DEF_MAX_TEX_HEIGHT,
    parameter int COLOR_BITS     = bts_pkg::DEF_COLOR_BITS,
    localparam int XW = $clog2(MAX_TEX_WIDTH),
    localparam int YW = $clog2(MAX_TEX_HEIGHT),
    localparam int DW = 3 * COLOR_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic                       req_accept,
    input  wire bts_pkg::req_word_t         req_word,
    input  wire bts_pkg::size_t             size,
    output bts_pkg::ctl_t                   b_ctl,
    output logic [XW-1:0]                   b_i0,
    output logic [XW-1:0]                   b_i1,
    output logic [YW-1:0]                   b_j0,
    output logic [YW-1:0]                   b_j1,
    output logic [bts_pkg::WT_W-1:0]        b_w00,
    output logic [bts_pkg::WT_W-1:0]        b_w10,
    output logic [bts_pkg::WT_W-1:0]        b_w01,
    output logic [bts_pkg::WT_W-1:0]        b_w11,
    output logic [DW-1:0]                   b_color
);

    localparam int CW = bts_pkg::CFG_W;

    // Stage A: scaled coordinates
    bts_pkg::ctl_t            a_ctl_reg, a_ctl_next;
    logic signed [41:0]       a_pu_reg, a_pu_next;
    logic signed [41:0]       a_pv_reg, a_pv_next;
    logic [24:0]              a_mu_reg, a_mu_next;
    logic [24:0]              a_mv_reg, a_mv_next;
    logic                     a_tile_reg;
    logic [7:0]               a_x_reg;
    logic [7:0]               a_y_reg;
    logic [DW-1:0]            a_color_reg, a_color_next;

    // Stage B: texel indices and weights
    bts_pkg::ctl_t            b_ctl_reg;
    logic [XW-1:0]            b_i0_reg, b_i0_next;
    logic [XW-1:0]            b_i1_reg, b_i1_next;
    logic [YW-1:0]            b_j0_reg, b_j0_next;
    logic [YW-1:0]            b_j1_reg, b_j1_next;
    logic [bts_pkg::WT_W-1:0] b_w00_reg, b_w00_next;
    logic [bts_pkg::WT_W-1:0] b_w10_reg, b_w10_next;
    logic [bts_pkg::WT_W-1:0] b_w01_reg, b_w01_next;
    logic [bts_pkg::WT_W-1:0] b_w11_reg, b_w11_next;
    logic [DW-1:0]            b_color_reg;

    logic [2*CW-1:0]          pair_u;
    logic [2*CW-1:0]          pair_v;
    logic [bts_pkg::WS_W-1:0] ws0, ws1, wt0, wt1;
    logic [2*bts_pkg::WS_W-1:0] w00_full, w10_full, w01_full, w11_full;
    logic [COLOR_BITS+15:0]   red_ext, green_ext, blue_ext;

    // Returns {lo, hi}: the index and its right or lower neighbor
    function automatic logic [2*CW-1:0] edge_pair(
        input logic signed [41:0] p,
        input logic [24:0]        m,
        input logic [CW-1:0]      sz,
        input logic               tile
    );
        logic [CW-1:0] szm1;
        logic [CW-1:0] lo;
        logic [CW-1:0] hi;
        logic [25:0]   iu;
        szm1 = sz - CW'(1);
        iu   = p[41:16];
        if (tile)
        begin
            // fraction part of u times size is already the wrapped index
            lo = m[24:16];
            hi = (lo == szm1) ? '0 : lo + CW'(1);
        end
        else if (p[41])
        begin
            lo = '0;
            hi = '0;
        end
        else
        begin
            lo = (iu > 26'(szm1)) ? szm1 : iu[CW-1:0];
            hi = (iu >= 26'(szm1)) ? szm1 : iu[CW-1:0] + CW'(1);
        end
        return {lo, hi};
    endfunction

    function automatic logic [XW-1:0] to_xw(input logic [CW-1:0] k);
        logic [XW+CW-1:0] e;
        e = {{XW{1'b0}}, k};
        return e[XW-1:0];
    endfunction

    function automatic logic [YW-1:0] to_yw(input logic [CW-1:0] k);
        logic [YW+CW-1:0] e;
        e = {{YW{1'b0}}, k};
        return e[YW-1:0];
    endfunction

    always_comb
    begin
        a_ctl_next.valid   = req_accept;
        a_ctl_next.sample  = (req_word.func == bts_pkg::FUNC_SAMPLE);
        a_ctl_next.present = size.present;
        a_ctl_next.wr_en   = req_accept && (req_word.func == bts_pkg::FUNC_WRITE)
                             && (32'(req_word.write_x) < MAX_TEX_WIDTH)
                             && (32'(req_word.write_y) < MAX_TEX_HEIGHT);
        a_pu_next = req_word.coord_u * $signed({1'b0, size.size_w});
        a_pv_next = req_word.coord_v * $signed({1'b0, size.size_h});
        a_mu_next = req_word.coord_u[15:0] * size.size_w;
        a_mv_next = req_word.coord_v[15:0] * size.size_h;
        red_ext   = {{COLOR_BITS{1'b0}}, req_word.color_red};
        green_ext = {{COLOR_BITS{1'b0}}, req_word.color_green};
        blue_ext  = {{COLOR_BITS{1'b0}}, req_word.color_blue};
        a_color_next = {blue_ext[COLOR_BITS-1:0], green_ext[COLOR_BITS-1:0],
                        red_ext[COLOR_BITS-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
        end
        else if (advance)
        begin
            a_ctl_reg <= a_ctl_next;
            b_ctl_reg <= a_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_pu_reg    <= a_pu_next;
            a_pv_reg    <= a_pv_next;
            a_mu_reg    <= a_mu_next;
            a_mv_reg    <= a_mv_next;
            a_tile_reg  <= req_word.tile_mode;
            a_x_reg     <= req_word.write_x;
            a_y_reg     <= req_word.write_y;
            a_color_reg <= a_color_next;
        end
    end

    always_comb
    begin
        pair_u = edge_pair(a_pu_reg, a_mu_reg, size.size_w, a_tile_reg);
        pair_v = edge_pair(a_pv_reg, a_mv_reg, size.size_h, a_tile_reg);

        // a write word carries its texel address on the i0/j0 lanes
        if (a_ctl_reg.sample)
        begin
            b_i0_next = to_xw(pair_u[2*CW-1:CW]);
            b_j0_next = to_yw(pair_v[2*CW-1:CW]);
        end
        else
        begin
            b_i0_next = to_xw({1'b0, a_x_reg});
            b_j0_next = to_yw({1'b0, a_y_reg});
        end
        b_i1_next = to_xw(pair_u[CW-1:0]);
        b_j1_next = to_yw(pair_v[CW-1:0]);

        ws1 = {1'b0, a_mu_reg[15:0]};
        wt1 = {1'b0, a_mv_reg[15:0]};
        ws0 = bts_pkg::WS_ONE - ws1;
        wt0 = bts_pkg::WS_ONE - wt1;
        w00_full = ws0 * wt0;
        w10_full = ws1 * wt0;
        w01_full = ws0 * wt1;
        w11_full = ws1 * wt1;
        b_w00_next = w00_full[bts_pkg::WT_W-1:0];
        b_w10_next = w10_full[bts_pkg::WT_W-1:0];
        b_w01_next = w01_full[bts_pkg::WT_W-1:0];
        b_w11_next = w11_full[bts_pkg::WT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_i0_reg    <= b_i0_next;
            b_i1_reg    <= b_i1_next;
            b_j0_reg    <= b_j0_next;
            b_j1_reg    <= b_j1_next;
            b_w00_reg   <= b_w00_next;
            b_w10_reg   <= b_w10_next;
            b_w01_reg   <= b_w01_next;
            b_w11_reg   <= b_w11_next;
            b_color_reg <= a_color_reg;
        end
    end

    assign b_ctl   = b_ctl_reg;
    assign b_i0    = b_i0_reg;
    assign b_i1    = b_i1_reg;
    assign b_j0    = b_j0_reg;
    assign b_j1    = b_j1_reg;
    assign b_w00   = b_w00_reg;
    assign b_w10   = b_w10_reg;
    assign b_w01   = b_w01_reg;
    assign b_w11   = b_w11_reg;
    assign b_color = b_color_reg;

endmodule

`default_nettype wire

// ===== rtl/bts_texel_mem.sv =====
// Texel store: two copies, one per texel row of the 2x2 footprint, each with
// one write port and two registered read ports. Depends on bts_pkg.
`default_nettype none

module bts_texel_mem #(
    parameter int MAX_TEX_WIDTH  = bts_pkg::DEF_MAX_TEX_WIDTH,
    parameter int MAX_TEX_HEIGHT = bts_pkg::DEF_MAX_TEX_HEIGHT,
    parameter int COLOR_BITS     = bts_pkg::DEF_COLOR_BITS,
    localparam int XW = $clog2(MAX_TEX_WIDTH),
    localparam int YW = $clog2(MAX_TEX_HEIGHT),
    localparam int DW = 3 * COLOR_BITS
) (
    input  wire logic            clk,
    input  wire logic            advance,
    input  wire bts_pkg::ctl_t   ctl,
    input  wire logic [XW-1:0]   i0,
    input  wire logic [XW-1:0]   i1,
    input  wire logic [YW-1:0]   j0,
    input  wire logic [YW-1:0]   j1,
    input  wire logic [DW-1:0]   wdata,
    output logic      [DW-1:0]   rd00,
    output logic      [DW-1:0]   rd10,
    output logic      [DW-1:0]   rd01,
    output logic      [DW-1:0]   rd11
);

    localparam int DEPTH = MAX_TEX_WIDTH * MAX_TEX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [DW-1:0] row0_mem [DEPTH];
    logic [DW-1:0] row1_mem [DEPTH];

    logic [AW-1:0] a00, a10, a01, a11;
    logic [DW-1:0] rd00_reg, rd10_reg, rd01_reg, rd11_reg;

    assign a00 = AW'(32'(j0) * MAX_TEX_WIDTH + 32'(i0));
    assign a10 = AW'(32'(j0) * MAX_TEX_WIDTH + 32'(i1));
    assign a01 = AW'(32'(j1) * MAX_TEX_WIDTH + 32'(i0));
    assign a11 = AW'(32'(j1) * MAX_TEX_WIDTH + 32'(i1));

    // Writes and reads share this stage, so program order is kept
    always_ff @(posedge clk)
    begin
        if (advance && ctl.wr_en)
        begin
            row0_mem[a00] <= wdata;
            row1_mem[a00] <= wdata;
        end
        if (advance)
        begin
            rd00_reg <= row0_mem[a00];
            rd10_reg <= row0_mem[a10];
            rd01_reg <= row1_mem[a01];
            rd11_reg <= row1_mem[a11];
        end
    end

    assign rd00 = rd00_reg;
    assign rd10 = rd10_reg;
    assign rd01 = rd01_reg;
    assign rd11 = rd11_reg;

endmodule

`default_nettype wire

// ===== rtl/bts_blend.sv =====
// Bilinear blend: weights the four texels, rounds, saturates and holds the
// result word, or passes the fallback color. Depends on bts_pkg.
`default_nettype none

module bts_blend #(
    parameter int COLOR_BITS = bts_pkg::DEF_COLOR_BITS,
    localparam int DW = 3 * COLOR_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire bts_pkg::ctl_t               b_ctl,
    input  wire logic [bts_pkg::WT_W-1:0]    b_w00,
    input  wire logic [bts_pkg::WT_W-1:0]    b_w10,
    input  wire logic [bts_pkg::WT_W-1:0]    b_w01,
    input  wire logic [bts_pkg::WT_W-1:0]    b_w11,
    input  wire logic [DW-1:0]               b_color,
    input  wire logic [DW-1:0]               rd00,
    input  wire logic [DW-1:0]               rd10,
    input  wire logic [DW-1:0]               rd01,
    input  wire logic [DW-1:0]               rd11,
    output logic                             rsp_valid,
    output bts_pkg::rsp_word_t               rsp_word
);

    localparam int CB = COLOR_BITS;
    localparam int PW = CB + bts_pkg::WT_W;
    localparam logic [PW-1:0] RND = PW'(33'h0_8000_0000);

    // Stage C: in step with the memory read data
    bts_pkg::ctl_t            c_ctl_reg;
    logic [bts_pkg::WT_W-1:0] c_w00_reg, c_w10_reg, c_w01_reg, c_w11_reg;
    logic [DW-1:0]            c_color_reg;

    // Stage D: products
    bts_pkg::ctl_t            d_ctl_reg;
    logic [DW-1:0]            d_color_reg;

    logic [15:0]              out16 [3];
    logic                     rsp_valid_reg;
    bts_pkg::rsp_word_t       rsp_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_ctl_reg     <= '0;
            d_ctl_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            c_ctl_reg     <= b_ctl;
            d_ctl_reg     <= c_ctl_reg;
            rsp_valid_reg <= d_ctl_reg.valid && d_ctl_reg.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_w00_reg   <= b_w00;
            c_w10_reg   <= b_w10;
            c_w01_reg   <= b_w01;
            c_w11_reg   <= b_w11;
            c_color_reg <= b_color;
            d_color_reg <= c_color_reg;
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_chan
        logic [PW-1:0]    d_p00_reg, d_p10_reg, d_p01_reg, d_p11_reg;
        logic [PW-1:0]    sum;
        logic [CB:0]      v;
        logic [CB-1:0]    blend;
        logic [CB+15:0]   blend_ext;
        logic [CB+15:0]   fall_ext;

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                d_p00_reg <= PW'(rd00[g*CB +: CB]) * PW'(c_w00_reg);
                d_p10_reg <= PW'(rd10[g*CB +: CB]) * PW'(c_w10_reg);
                d_p01_reg <= PW'(rd01[g*CB +: CB]) * PW'(c_w01_reg);
                d_p11_reg <= PW'(rd11[g*CB +: CB]) * PW'(c_w11_reg);
            end
        end

        always_comb
        begin
            // weights sum to 1 << 32: round half up, then drop the fraction
            sum   = d_p00_reg + d_p10_reg + d_p01_reg + d_p11_reg + RND;
            v     = sum[PW-1:2*bts_pkg::FRAC_W];
            blend = v[CB] ? '1 : v[CB-1:0];
            blend_ext = {16'b0, blend};
            fall_ext  = {16'b0, d_color_reg[g*CB +: CB]};
            out16[g]  = d_ctl_reg.present ? blend_ext[15:0] : fall_ext[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_word_reg.sample_red   <= out16[0];
            rsp_word_reg.sample_green <= out16[1];
            rsp_word_reg.sample_blue  <= out16[2];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

`default_nettype wire

// ===== rtl/bilinear_texture_sampler.sv =====
// Top level of the bilinear texture sampler: register port, coordinate front
// end, texel store and blend. Depends on bts_pkg and the bts_* modules.
`default_nettype none

// The sampler takes one word per clock, a texel write or a sample, and
// returns one word per sample from its output register, none for a
// write. Throughput is one word per cycle while rsp_stall is low; a stall
// holds the whole pipeline, so at most one finished word waits at the output
// while the input is held. The texel store is kept as two copies, one per row
// of the 2x2 footprint, each read at two addresses per cycle, which is what
// sets the single-cycle rate. Writes and sample reads hit the store in the
// same stage, so a sample sees every write taken before it. The store has no
// reset and no clearing pass: only texels that were written may be sampled.
// Registers (byte addresses): 0 texture width, 4 texture height, 8 texture
// present; write them only while no word is in flight.
module bilinear_texture_sampler #(
    parameter int MAX_TEX_WIDTH  = bts_pkg::DEF_MAX_TEX_WIDTH,
    parameter int MAX_TEX_HEIGHT = bts_pkg::DEF_MAX_TEX_HEIGHT,
    parameter int COLOR_BITS     = bts_pkg::DEF_COLOR_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire bts_pkg::req_word_t          req_word,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output bts_pkg::rsp_word_t               rsp_word,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bts_pkg::APB_AW-1:0]  paddr,
    input  wire logic [bts_pkg::APB_DW-1:0]  pwdata,
    output logic      [bts_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);

    localparam int XW = $clog2(MAX_TEX_WIDTH);
    localparam int YW = $clog2(MAX_TEX_HEIGHT);
    localparam int DW = 3 * COLOR_BITS;

    logic                     advance;
    logic                     req_accept;
    bts_pkg::size_t           size;
    bts_pkg::ctl_t            b_ctl;
    logic [XW-1:0]            b_i0, b_i1;
    logic [YW-1:0]            b_j0, b_j1;
    logic [bts_pkg::WT_W-1:0] b_w00, b_w10, b_w01, b_w11;
    logic [DW-1:0]            b_color;
    logic [DW-1:0]            rd00, rd10, rd01, rd11;

    // advance the pipeline unless the held output word is stalled
    assign advance    = !(rsp_valid && rsp_stall);
    assign req_stall  = !advance;
    assign req_accept = req_valid && advance;

    bts_cfg_regs #(
        .MAX_TEX_WIDTH  (MAX_TEX_WIDTH),
        .MAX_TEX_HEIGHT (MAX_TEX_HEIGHT)
    ) u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .size    (size)
    );

    bts_addr_gen #(
        .MAX_TEX_WIDTH  (MAX_TEX_WIDTH),
        .MAX_TEX_HEIGHT (MAX_TEX_HEIGHT),
        .COLOR_BITS     (COLOR_BITS)
    ) u_addr_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .req_accept (req_accept),
        .req_word   (req_word),
        .size       (size),
        .b_ctl      (b_ctl),
        .b_i0       (b_i0),
        .b_i1       (b_i1),
        .b_j0       (b_j0),
        .b_j1       (b_j1),
        .b_w00      (b_w00),
        .b_w10      (b_w10),
        .b_w01      (b_w01),
        .b_w11      (b_w11),
        .b_color    (b_color)
    );

    bts_texel_mem #(
        .MAX_TEX_WIDTH  (MAX_TEX_WIDTH),
        .MAX_TEX_HEIGHT (MAX_TEX_HEIGHT),
        .COLOR_BITS     (COLOR_BITS)
    ) u_texel_mem (
        .clk     (clk),
        .advance (advance),
        .ctl     (b_ctl),
        .i0      (b_i0),
        .i1      (b_i1),
        .j0      (b_j0),
        .j1      (b_j1),
        .wdata   (b_color),
        .rd00    (rd00),
        .rd10    (rd10),
        .rd01    (rd01),
        .rd11    (rd11)
    );

    bts_blend #(
        .COLOR_BITS (COLOR_BITS)
    ) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .b_ctl     (b_ctl),
        .b_w00     (b_w00),
        .b_w10     (b_w10),
        .b_w01     (b_w01),
        .b_w11     (b_w11),
        .b_color   (b_color),
        .rd00      (rd00),
        .rd10      (rd10),
        .rd01      (rd01),
        .rd11      (rd11),
        .rsp_valid (rsp_valid),
        .rsp_word  (rsp_word)
    );

endmodule

`default_nettype wire

// ===== rtl/bts_checker.sv =====
// Port-level checks of the sampler, bound to the top level.
// Depends on bts_pkg and bilinear_texture_sampler.
`default_nettype none

module bts_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_stall,
    input wire bts_pkg::req_word_t          req_word,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_stall,
    input wire bts_pkg::rsp_word_t          rsp_word,
    input wire logic                        psel,
    input wire logic                        penable,
    input wire logic                        pwrite,
    input wire logic [bts_pkg::APB_AW-1:0]  paddr,
    input wire logic [bts_pkg::APB_DW-1:0]  pwdata,
    input wire logic [bts_pkg::APB_DW-1:0]  prdata
);

    // the input is held back only by a stalled output word
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("input stalled without a stalled output word");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
        else $error("stalled output word changed or dropped");

    // a sample comes out on rsp_valid if the input is not stalled while it is in flight
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req_word.func == bts_pkg::FUNC_SAMPLE)
        ##1 !req_stall ##1 !req_stall ##1 !req_stall ##1 !req_stall
        |=> rsp_valid)
        else $error("sample word did not arrive after five cycles");

    a_present_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && !pwrite && paddr[3:2] == bts_pkg::REG_PRESENT && $past(rst_n)
         && $past(psel && penable && pwrite && paddr[3:2] == bts_pkg::REG_PRESENT))
        |-> (prdata[0] == $past(pwdata[0])))
        else $error("present flag reads back wrong after a write");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

`default_nettype wire
